// ===== sv/mks_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and key code lookup for the keypad scanner.
package mks_pkg;

   localparam int ROWS                 = 4;
   localparam int COLS                 = 4;
   localparam int ROW_W                = 2;
   localparam int COL_W                = 2;
   localparam int CODE_W               = 8;
   localparam int CSR_INDEX_W          = 8;
   localparam int CSR_DATA_W           = 64;
   localparam int DEBOUNCE_SAMPLES_DEF = 4;

   localparam logic [CSR_DATA_W-1:0] CODES_LO_RESET = 64'd2681389126241169969;
   localparam logic [CSR_DATA_W-1:0] CODES_HI_RESET = 64'd2813935235823646775;

   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [COL_W-1:0]       col_type;
   typedef logic [CODE_W-1:0]      code_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CODES_ROWS_0_1 = 8'd0,
      REG_CODES_ROWS_2_3 = 8'd1
   } csr_reg_type;

   // one scanned row handed from the lanes to the output stage
   typedef struct packed {
      row_type                  active_row;
      logic [COLS-1:0]          press;
      code_type [COLS-1:0]      codes;
   } scan_type;

   function automatic code_type code_of(input csr_data_type lo, input csr_data_type hi,
                                        input row_type row, input col_type col);
      csr_data_type tbl;
      tbl = row[1] ? hi : lo;
      return tbl[{row[0], col, 3'b000} +: CODE_W];
   endfunction

endpackage

// ===== sv/mks_if.sv =====
`timescale 1ns / 1ps
// Request, response and register write channels of the keypad scanner.
interface mks_req_if;
   logic                            valid;
   logic                            ready;
   logic [mks_pkg::COLS-1:0]        column_levels;

   modport source (output valid, output column_levels, input ready);
   modport sink   (input valid, input column_levels, output ready);
endinterface

interface mks_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mks_pkg::ROW_W-1:0]       active_row;
   logic                            key_valid;
   logic [mks_pkg::CODE_W-1:0]      key_code;
   logic                            last_result;

   modport source (output valid, output active_row, output key_valid, output key_code,
                   output last_result, input ready);
   modport sink   (input valid, input active_row, input key_valid, input key_code,
                   input last_result, output ready);
endinterface

interface mks_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mks_pkg::CSR_INDEX_W-1:0] index;
   logic [mks_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mks_lane.sv =====
`timescale 1ns / 1ps
// One column lane: sample history and debounced level of the four keys of a column.
module mks_lane #(
   parameter int DEBOUNCE_SAMPLES = mks_pkg::DEBOUNCE_SAMPLES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             upd,
   input  mks_pkg::row_type row,
   input  logic             level,
   output logic             press
);
   import mks_pkg::*;

   logic [DEBOUNCE_SAMPLES-1:0] hist_ff [ROWS];
   logic [ROWS-1:0]             stable_ff;
   logic [DEBOUNCE_SAMPLES-1:0] hist_in;
   logic                        stable_in;

   always_comb begin
      hist_in   = {hist_ff[row][DEBOUNCE_SAMPLES-2:0], level};
      stable_in = stable_ff[row];
      if (&hist_in) begin
         stable_in = 1'b1;
      end else if (~|hist_in) begin
         stable_in = 1'b0;
      end
   end

   // a press is the debounced level falling from released to pressed
   assign press = stable_ff[row] & ~stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            hist_ff[r] <= '1;
         end
         stable_ff <= '1;
      end else if (upd) begin
         hist_ff[row]   <= hist_in;
         stable_ff[row] <= stable_in;
      end
   end

endmodule

// ===== sv/mks_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: holds scanned rows and serializes their press codes onto the response channel.
module mks_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mks_pkg::scan_type in_scan,
   mks_rsp_if.source         rsp_ch
);
   import mks_pkg::*;

   logic                a_valid_ff, a_valid_in;
   scan_type            a_scan_ff, a_scan_in;
   logic                b_valid_ff, b_valid_in;
   row_type             b_row_ff, b_row_in;
   logic [COLS-1:0]     b_mask_ff, b_mask_in;
   code_type [COLS-1:0] b_codes_ff, b_codes_in;

   col_type             sel;
   logic [COLS-1:0]     rest;
   logic                last;
   logic                b_take, b_done, b_free, a_move, in_fire;

   always_comb begin
      sel = '0;
      for (int i = COLS - 1; i >= 0; i--) begin
         if (b_mask_ff[i]) begin
            sel = col_type'(i);
         end
      end
   end

   assign rest     = b_mask_ff & (b_mask_ff - 1'b1);
   assign last     = (rest == '0);
   assign b_take   = b_valid_ff & rsp_ch.ready;
   assign b_done   = b_take & last;
   assign b_free   = ~b_valid_ff | b_done;
   assign a_move   = a_valid_ff & b_free;
   assign in_ready = ~a_valid_ff | b_free;
   assign in_fire  = in_valid & in_ready;

   assign rsp_ch.valid       = b_valid_ff;
   assign rsp_ch.active_row  = b_row_ff;
   assign rsp_ch.key_valid   = |b_mask_ff;
   assign rsp_ch.key_code    = (|b_mask_ff) ? b_codes_ff[sel] : '0;
   assign rsp_ch.last_result = last;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_scan_in  = a_scan_ff;
      if (in_fire) begin
         a_valid_in = 1'b1;
         a_scan_in  = in_scan;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end

      b_valid_in = b_valid_ff;
      b_row_in   = b_row_ff;
      b_mask_in  = b_mask_ff;
      b_codes_in = b_codes_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
         b_row_in   = a_scan_ff.active_row;
         b_mask_in  = a_scan_ff.press;
         b_codes_in = a_scan_ff.codes;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (b_take) begin
         b_mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_scan_ff  <= a_scan_in;
      b_row_ff   <= b_row_in;
      b_mask_ff  <= b_mask_in;
      b_codes_ff <= b_codes_in;
   end

endmodule

// ===== sv/matrix_keypad_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the 4x4 keypad scanner with per-key debounce.
//
//   channel  | dir | payload                                        | request
//   ---------+-----+------------------------------------------------+---------------------
//   req_ch   | in  | column_levels                                  | one scan tick
//   rsp_ch   | out | active_row, key_valid, key_code, last_result   | one press or none
//   csr_ch   | in  | index, data                                    | key code table write
//
// A request is taken every cycle while it yields one response and rsp_ch ready stays high;
// a tick with n presses holds the response port for n responses, set by the single output serializer.
// A taken request is registered in the holding stage, then in the serializer stage that drives rsp_ch.
// Reset: histories released, row 0, default code table; no clearing pass.
// A stalled response holds; one more request is buffered before req ready drops.
module matrix_keypad_scanner #(
   parameter int DEBOUNCE_SAMPLES = mks_pkg::DEBOUNCE_SAMPLES_DEF
) (
   input logic        clock,
   input logic        reset,
   mks_req_if.sink    req_ch,
   mks_rsp_if.source  rsp_ch,
   mks_csr_if.sink    csr_ch
);
   import mks_pkg::*;

   csr_data_type    codes_lo_ff;
   csr_data_type    codes_hi_ff;
   row_type         row_ff;
   logic            req_fire;
   logic [COLS-1:0] press;
   scan_type        scan;

   assign req_fire     = req_ch.valid & req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_lo_ff <= CODES_LO_RESET;
         codes_hi_ff <= CODES_HI_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_CODES_ROWS_0_1: codes_lo_ff <= csr_ch.data;
            REG_CODES_ROWS_2_3: codes_hi_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (req_fire) begin
         row_ff <= row_ff + 1'b1;
      end
   end

   for (genvar c = 0; c < COLS; c++) begin : g_lane
      mks_lane #(
         .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .upd   (req_fire),
         .row   (row_ff),
         .level (req_ch.column_levels[c]),
         .press (press[c])
      );
      assign scan.codes[c] = code_of(codes_lo_ff, codes_hi_ff, row_ff, col_type'(c));
   end

   assign scan.active_row = row_ff + 1'b1;
   assign scan.press      = press;

   mks_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_scan  (scan),
      .rsp_ch   (rsp_ch)
   );

   a_idle_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.key_valid |-> rsp_ch.last_result && rsp_ch.key_code == '0)
      else $error("response without key is not the final one of its tick");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> row_ff == row_type'($past(row_ff) + 1'b1))
      else $error("row index did not advance on a taken request");

   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(row_ff))
      else $error("row index moved without a request");

endmodule
